### sv/ihr_pkg.sv
// shared types and constants for the id handle registry
package ihr_pkg;

   localparam int unsigned ID_W     = 32;
   localparam int unsigned HANDLE_W = 32;
   localparam int unsigned OP_W     = 2;
   localparam int unsigned STATUS_W = 2;

   // packed stream widths, rounded up to whole bytes
   localparam int unsigned REQ_FIELDS_W = OP_W + ID_W + HANDLE_W;
   localparam int unsigned REQ_TDATA_W  = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int unsigned RSP_FIELDS_W = STATUS_W + HANDLE_W;
   localparam int unsigned RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam logic [ID_W-1:0] MARKER_RESET = 32'hFFFF_FFFF;

   typedef enum logic [OP_W-1:0] {
      OP_ADD    = 2'd0,
      OP_LOOKUP = 2'd1,
      OP_REMOVE = 2'd2
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK   = 2'd0,
      STATUS_DUP  = 2'd1,
      STATUS_FULL = 2'd2,
      STATUS_MISS = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE   = 2'd0,
      S_SCAN   = 2'd1,
      S_FINISH = 2'd2
   } state_type;

endpackage

### sv/ihr_slot_store.sv
// slot identifier and handle memories with per-slot valid bits
module ihr_slot_store #(
   parameter  int unsigned SLOTS = 16,
   localparam int unsigned IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          rd_en,
   input  logic [IW-1:0]                 rd_addr,
   output logic [ihr_pkg::ID_W-1:0]      rd_id,
   output logic [ihr_pkg::HANDLE_W-1:0]  rd_handle,
   input  logic                          wr_en,
   input  logic [IW-1:0]                 wr_addr,
   input  logic [ihr_pkg::ID_W-1:0]      wr_id,
   input  logic [ihr_pkg::HANDLE_W-1:0]  wr_handle
);

   logic [ihr_pkg::ID_W-1:0]     id_mem     [SLOTS];
   logic [ihr_pkg::HANDLE_W-1:0] handle_mem [SLOTS];
   logic [SLOTS-1:0]             valid_ff;
   logic [SLOTS-1:0]             valid_in;
   logic [ihr_pkg::ID_W-1:0]     rd_id_ff;
   logic [ihr_pkg::HANDLE_W-1:0] rd_handle_ff;
   logic                         rd_valid_ff;

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         id_mem[wr_addr]     <= wr_id;
         handle_mem[wr_addr] <= wr_handle;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_id_ff     <= id_mem[rd_addr];
         rd_handle_ff <= handle_mem[rd_addr];
         rd_valid_ff  <= valid_ff[rd_addr];
      end
   end

   // a never written slot reads as its reset contents
   assign rd_id     = rd_valid_ff ? rd_id_ff : ihr_pkg::MARKER_RESET;
   assign rd_handle = rd_valid_ff ? rd_handle_ff : '0;

endmodule

### sv/id_handle_registry.sv
// id handle registry top level: sequenced slot scan, update and response
//
//  channel | ports                          | direction | contents
//  --------+--------------------------------+-----------+---------------------------------
//  req     | req_tvalid/req_tready/req_tdata| in        | op, key_id, new_handle
//  rsp     | rsp_tvalid/rsp_tready/rsp_tdata| out       | status, found_handle
//  csr     | csr_valid/csr_ready/csr_data   | in        | free_marker write, always ready
//
// a transaction reads and compares one slot per cycle through the
// single read port of the slot memory, then the final step decides and writes back
// req_tready is high only while the sequencer is idle; a finished result waits in the rsp
// register and the next request is accepted meanwhile
// a stalled rsp holds the sequencer in its final step until the register frees up
// synchronous active-high reset frees all slots at once through valid bits, no clearing pass
module id_handle_registry #(
   parameter int unsigned SLOTS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [1:0] op, [33:2] key_id, [65:34] new_handle, rest zero
   input  logic [ihr_pkg::REQ_TDATA_W-1:0]    req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [1:0] status, [33:2] found_handle, rest zero
   output logic [ihr_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ihr_pkg::ID_W-1:0]           csr_data
);

   localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int unsigned OP_LO  = 0;
   localparam int unsigned KEY_LO = OP_LO + ihr_pkg::OP_W;
   localparam int unsigned HDL_LO = KEY_LO + ihr_pkg::ID_W;

   // sequencer state
   ihr_pkg::state_type state_ff, state_in;

   // captured request
   ihr_pkg::op_type               op_ff;
   logic [ihr_pkg::ID_W-1:0]      key_ff;
   logic [ihr_pkg::HANDLE_W-1:0]  handle_ff;

   // free marker register
   logic [ihr_pkg::ID_W-1:0]      marker_ff;

   // scan counters: issue side, and compare side registered from it in the next cycle
   logic [IW:0]                   issue_cnt_ff, issue_cnt_in;
   logic                          pipe_vld_ff, pipe_vld_in;
   logic [IW-1:0]                 pipe_idx_ff;

   // first-match trackers
   logic                          hit_found_ff, hit_found_in;
   logic [IW-1:0]                 hit_idx_ff, hit_idx_in;
   logic [ihr_pkg::HANDLE_W-1:0]  hit_handle_ff, hit_handle_in;
   logic                          free_found_ff, free_found_in;
   logic [IW-1:0]                 free_idx_ff, free_idx_in;

   // response register
   logic                          rsp_valid_ff, rsp_valid_in;
   ihr_pkg::status_type           rsp_status_ff;
   logic [ihr_pkg::HANDLE_W-1:0]  rsp_handle_ff;

   // control outputs of the sequencer
   logic                          accept;
   logic                          rd_en;
   logic                          rsp_load;
   logic                          rsp_free;
   logic                          scan_last;

   // store ports
   logic [ihr_pkg::ID_W-1:0]      rd_id;
   logic [ihr_pkg::HANDLE_W-1:0]  rd_handle;
   logic                          wr_en;
   logic [IW-1:0]                 wr_addr;
   logic [ihr_pkg::ID_W-1:0]      wr_id;
   logic [ihr_pkg::HANDLE_W-1:0]  wr_handle;

   // decision of the final step
   ihr_pkg::status_type           res_status;
   logic [ihr_pkg::HANDLE_W-1:0]  res_handle;
   logic                          key_hit;
   logic                          free_hit;

   ihr_slot_store #(
      .SLOTS (SLOTS)
   ) u_store (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (rd_en),
      .rd_addr   (issue_cnt_ff[IW-1:0]),
      .rd_id     (rd_id),
      .rd_handle (rd_handle),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_id     (wr_id),
      .wr_handle (wr_handle)
   );

   // the shared compare unit: one slot's contents against key and marker each cycle
   assign key_hit  = pipe_vld_ff && (rd_id == key_ff);
   assign free_hit = pipe_vld_ff && (rd_id == marker_ff);

   assign scan_last = pipe_vld_ff && (pipe_idx_ff == IW'(SLOTS - 1));
   assign rsp_free  = !rsp_valid_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ihr_pkg::S_IDLE: begin
            if (req_tvalid) begin
               state_in = ihr_pkg::S_SCAN;
            end
         end
         ihr_pkg::S_SCAN: begin
            if (scan_last) begin
               state_in = ihr_pkg::S_FINISH;
            end
         end
         ihr_pkg::S_FINISH: begin
            if (rsp_free) begin
               state_in = ihr_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = ihr_pkg::S_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready = 1'b0;
      rd_en      = 1'b0;
      rsp_load   = 1'b0;
      case (state_ff)
         ihr_pkg::S_IDLE: begin
            req_tready = 1'b1;
         end
         ihr_pkg::S_SCAN: begin
            rd_en = (issue_cnt_ff < (IW+1)'(SLOTS));
         end
         ihr_pkg::S_FINISH: begin
            rsp_load = rsp_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   assign accept = req_tvalid && req_tready;

   // scan bookkeeping
   always_comb begin
      issue_cnt_in  = issue_cnt_ff;
      pipe_vld_in   = rd_en;
      hit_found_in  = hit_found_ff;
      hit_idx_in    = hit_idx_ff;
      hit_handle_in = hit_handle_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      if (accept) begin
         issue_cnt_in  = '0;
         hit_found_in  = 1'b0;
         free_found_in = 1'b0;
      end else begin
         if (rd_en) begin
            issue_cnt_in = issue_cnt_ff + 1'b1;
         end
         // only the lowest-numbered match is kept
         if (key_hit && !hit_found_ff) begin
            hit_found_in  = 1'b1;
            hit_idx_in    = pipe_idx_ff;
            hit_handle_in = rd_handle;
         end
         if (free_hit && !free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = pipe_idx_ff;
         end
      end
   end

   // result and write-back of the final step
   always_comb begin
      res_status = ihr_pkg::STATUS_MISS;
      res_handle = '0;
      wr_en      = 1'b0;
      wr_addr    = hit_idx_ff;
      wr_id      = marker_ff;
      wr_handle  = '0;
      case (op_ff)
         ihr_pkg::OP_ADD: begin
            if (hit_found_ff) begin
               res_status = ihr_pkg::STATUS_DUP;
            end else if (free_found_ff) begin
               res_status = ihr_pkg::STATUS_OK;
               wr_en      = rsp_load;
               wr_addr    = free_idx_ff;
               wr_id      = key_ff;
               wr_handle  = handle_ff;
            end else begin
               res_status = ihr_pkg::STATUS_FULL;
            end
         end
         ihr_pkg::OP_LOOKUP: begin
            if (hit_found_ff) begin
               res_status = ihr_pkg::STATUS_OK;
               res_handle = hit_handle_ff;
            end
         end
         ihr_pkg::OP_REMOVE: begin
            // freed slot takes the current marker and loses its handle
            if (hit_found_ff) begin
               res_status = ihr_pkg::STATUS_OK;
               wr_en      = rsp_load;
            end
         end
         default: begin
            res_status = ihr_pkg::STATUS_MISS;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ihr_pkg::S_IDLE;
         pipe_vld_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         hit_found_ff  <= 1'b0;
         free_found_ff <= 1'b0;
         issue_cnt_ff  <= '0;
         marker_ff     <= ihr_pkg::MARKER_RESET;
      end else begin
         state_ff      <= state_in;
         pipe_vld_ff   <= pipe_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
         hit_found_ff  <= hit_found_in;
         free_found_ff <= free_found_in;
         issue_cnt_ff  <= issue_cnt_in;
         if (csr_valid && csr_ready) begin
            marker_ff <= csr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= ihr_pkg::op_type'(req_tdata[OP_LO +: ihr_pkg::OP_W]);
         key_ff    <= req_tdata[KEY_LO +: ihr_pkg::ID_W];
         handle_ff <= req_tdata[HDL_LO +: ihr_pkg::HANDLE_W];
      end
      pipe_idx_ff   <= issue_cnt_ff[IW-1:0];
      hit_idx_ff    <= hit_idx_in;
      hit_handle_ff <= hit_handle_in;
      free_idx_ff   <= free_idx_in;
      if (rsp_load) begin
         rsp_status_ff <= res_status;
         rsp_handle_ff <= res_handle;
      end
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(ihr_pkg::RSP_TDATA_W - ihr_pkg::RSP_FIELDS_W)'(0),
                        rsp_handle_ff, rsp_status_ff};

`ifndef ASSERT_OFF
   // a new request is never taken while the previous one is still being scanned
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("request accepted during a scan");

   // slot memory is only written in the final step together with the response load
   a_write_with_rsp: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (rsp_load && state_ff == ihr_pkg::S_FINISH))
      else $error("slot write outside final step");

   // compare stage never looks beyond the last slot
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      pipe_vld_ff |-> (pipe_idx_ff <= IW'(SLOTS - 1)))
      else $error("scan index out of range");

   // a handle is only reported with a successful lookup
   a_handle_only_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && res_handle != '0) |->
         (res_status == ihr_pkg::STATUS_OK && op_ff == ihr_pkg::OP_LOOKUP))
      else $error("handle reported without a successful lookup");
`endif

endmodule
